// ----- design/fresh_peer_table_core_macros.svh -----
// Assertion macros used by the fresh peer table core.
`ifndef FRESH_PEER_TABLE_CORE_MACROS_SVH
`define FRESH_PEER_TABLE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fresh peer table assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fresh peer table assertion failed");

`endif

// ----- design/fpt_pkg.sv -----
// Package with the shared widths, constants and types of the fresh peer table.
`timescale 1ns / 1ps
package fpt_pkg;

    localparam int ADDR_W             = 32;
    localparam int PORT_W             = 16;
    localparam int TICK_W             = 32;
    localparam int PEER_SLOTS_DEFAULT = 8;

    localparam logic [TICK_W-1:0] FRESH_WINDOW_RESET = TICK_W'(5000);

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic [TICK_W-1:0] seen;
    } t_peer;

endpackage

// ----- design/fpt_in_if.sv -----
// Interface of the send event channel.
`timescale 1ns / 1ps
interface fpt_in_if
    import fpt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] dest_addr;
    logic [PORT_W-1:0] dest_port;
    logic [TICK_W-1:0] now_ms;

    modport source (output valid, dest_addr, dest_port, now_ms, input ready);
    modport sink   (input valid, dest_addr, dest_port, now_ms, output ready);
endinterface

// ----- design/fpt_out_if.sv -----
// Interface of the fresh peer result channel.
`timescale 1ns / 1ps
interface fpt_out_if
    import fpt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] fresh_addr;
    logic [PORT_W-1:0] fresh_port;
    logic              last_peer;

    modport source (output valid, fresh_addr, fresh_port, last_peer, input ready);
    modport sink   (input valid, fresh_addr, fresh_port, last_peer, output ready);
endinterface

// ----- design/fpt_cell.sv -----
// One slot of the peer ring: holds an endpoint and hands it to its neighbour on a shift.
`timescale 1ns / 1ps
module fpt_cell
    import fpt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_peer i_d,
    output t_peer o_q
);

    logic [ADDR_W-1:0] r_addr;
    logic [PORT_W-1:0] r_port;
    logic [TICK_W-1:0] r_seen;

    // A zero port marks the slot as empty, so only the port needs clearing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port <= '0;
        end else if (i_shift) begin
            r_port <= i_d.port;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_addr <= i_d.addr;
            r_seen <= i_d.seen;
        end
    end

    assign o_q.addr = r_addr;
    assign o_q.port = r_port;
    assign o_q.seen = r_seen;

endmodule

// ----- design/fresh_peer_table_core.sv -----
// Top level of the fresh peer table: peer ring, scan and emit control, result register.
`timescale 1ns / 1ps
// Usage:
// Send events enter on i_in (valid/ready); each carries an address, a port and the
// current millisecond tick. Results leave on o_out (valid/ready), one fresh peer per
// item in slot order, with last_peer set on the final one. An event with no fresh
// peer yields no result. The freshness window is written through i_cfg_we and
// i_cfg_wdata, by the user only while the block is idle; the block does no such check.
// The slots form a ring of PEER_SLOTS cells that rotates one place a cycle while the
// block scans, or emits to a free receiver. An event is handled in three steps: a full
// rotation scans for a match, an empty slot and the oldest entry, a fix step picks the
// slot to update, and a second rotation writes it and emits results.
// A stalled receiver holds the result register and stops the emit rotation, so no
// result is dropped; a new event is accepted while the last result still waits.
// Reset empties every slot and sets the window to 5000 ms.
`include "fresh_peer_table_core_macros.svh"
module fresh_peer_table_core
    import fpt_pkg::*;
#(
    parameter int PEER_SLOTS = PEER_SLOTS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TICK_W-1:0] i_cfg_wdata,
    fpt_in_if.sink            i_in,
    fpt_out_if.source         o_out
);

    localparam int SW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam logic [SW-1:0] LAST_STEP = SW'(PEER_SLOTS - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FIX  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [TICK_W-1:0]     r_window;
    logic [ADDR_W-1:0]     r_ev_addr;
    logic [PORT_W-1:0]     r_ev_port;
    logic [TICK_W-1:0]     r_ev_now;
    logic [SW-1:0]         r_step, n_step;
    logic                  r_match_hit, n_match_hit;
    logic [SW-1:0]         r_match_idx, n_match_idx;
    logic                  r_empty_hit, n_empty_hit;
    logic [SW-1:0]         r_empty_idx, n_empty_idx;
    logic [SW-1:0]         r_victim_idx, n_victim_idx;
    logic [TICK_W-1:0]     r_victim_age, n_victim_age;
    logic [SW-1:0]         r_target, n_target;
    logic [PEER_SLOTS-1:0] r_fresh, n_fresh;

    logic                  r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]     r_out_addr, n_out_addr;
    logic [PORT_W-1:0]     r_out_port, n_out_port;
    logic                  r_out_last, n_out_last;

    t_peer                 w_cell_q [PEER_SLOTS];
    t_peer                 w_cell_d [PEER_SLOTS];
    t_peer                 w_head;
    t_peer                 w_upd;
    t_peer                 w_tail;
    logic                  w_shift;
    logic                  w_out_free;
    logic                  w_accept;
    logic                  w_emit;
    logic [TICK_W-1:0]     w_age;
    logic [SW-1:0]         w_target;

    genvar g;
    generate
        for (g = 0; g < PEER_SLOTS; g++) begin : g_cell
            if (g == PEER_SLOTS - 1) begin : g_tail
                assign w_cell_d[g] = w_tail;
            end else begin : g_link
                assign w_cell_d[g] = w_cell_q[g + 1];
            end
            fpt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_d     (w_cell_d[g]),
                .o_q     (w_cell_q[g])
            );
        end
    endgenerate

    assign w_head     = w_cell_q[0];
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_age      = r_ev_now - w_head.seen;
    assign w_target   = r_match_hit ? r_match_idx :
                        (r_empty_hit ? r_empty_idx : r_victim_idx);

    always_comb begin
        w_upd = w_head;
        if (r_step == r_target) begin
            w_upd.addr = r_ev_addr;
            w_upd.port = r_ev_port;
            w_upd.seen = r_ev_now;
        end
    end

    assign w_tail  = (r_state == S_EMIT) ? w_upd : w_head;
    assign w_shift = (r_state == S_SCAN) || ((r_state == S_EMIT) && w_out_free);
    assign w_emit  = (r_state == S_EMIT) && w_out_free && r_fresh[0];

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_match_hit  = r_match_hit;
        n_match_idx  = r_match_idx;
        n_empty_hit  = r_empty_hit;
        n_empty_idx  = r_empty_idx;
        n_victim_idx = r_victim_idx;
        n_victim_age = r_victim_age;
        n_target     = r_target;
        n_fresh      = r_fresh;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state      = S_SCAN;
                    n_step       = '0;
                    n_match_hit  = 1'b0;
                    n_empty_hit  = 1'b0;
                    n_victim_idx = '0;
                    n_victim_age = '0;
                end
            end
            S_SCAN: begin
                if (!r_match_hit && (w_head.port == r_ev_port) && (w_head.addr == r_ev_addr)) begin
                    n_match_hit = 1'b1;
                    n_match_idx = r_step;
                end
                if (!r_empty_hit && (w_head.port == '0)) begin
                    n_empty_hit = 1'b1;
                    n_empty_idx = r_step;
                end
                if (w_age >= r_victim_age) begin
                    n_victim_age = w_age;
                    n_victim_idx = r_step;
                end
                n_fresh = r_fresh >> 1;
                n_fresh[PEER_SLOTS-1] = (w_head.port != '0) && (w_age <= r_window);
                n_step  = r_step + SW'(1);
                if (r_step == LAST_STEP) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                n_target = w_target;
                for (int i = 0; i < PEER_SLOTS; i++) begin
                    if (SW'(i) == w_target) begin
                        n_fresh[i] = (r_ev_port != '0);
                    end
                end
                n_step  = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_fresh = r_fresh >> 1;
                    n_step  = r_step + SW'(1);
                    if (r_step == LAST_STEP) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_addr  = r_out_addr;
        n_out_port  = r_out_port;
        n_out_last  = r_out_last;
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out_addr  = w_upd.addr;
            n_out_port  = w_upd.port;
            n_out_last  = ((r_fresh >> 1) == '0);
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= FRESH_WINDOW_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ev_addr <= i_in.dest_addr;
            r_ev_port <= i_in.dest_port;
            r_ev_now  <= i_in.now_ms;
        end
        r_step       <= n_step;
        r_match_hit  <= n_match_hit;
        r_match_idx  <= n_match_idx;
        r_empty_hit  <= n_empty_hit;
        r_empty_idx  <= n_empty_idx;
        r_victim_idx <= n_victim_idx;
        r_victim_age <= n_victim_age;
        r_target     <= n_target;
        r_fresh      <= n_fresh;
        r_out_addr   <= n_out_addr;
        r_out_port   <= n_out_port;
        r_out_last   <= n_out_last;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.fresh_addr = r_out_addr;
    assign o_out.fresh_port = r_out_port;
    assign o_out.last_peer  = r_out_last;

    `FPT_ASSERT_NEXT(a_accept_starts_scan, w_accept, (r_state == S_SCAN) && (r_step == '0))
    `FPT_ASSERT_NEXT(a_fix_leads_to_emit, r_state == S_FIX, (r_state == S_EMIT) && (r_step == '0))
    `FPT_ASSERT_NEXT(a_emit_loads_result, w_emit, o_out.valid)
    `FPT_ASSERT_SAME(a_ring_still_in_idle, r_state == S_IDLE, !w_shift)

endmodule
